[rtl/rws_pkg.sv]
`default_nettype none
package rws_pkg;
    localparam int MAX_WINDOW_DEF = 64;
    localparam int SAMPLE_W       = 32;
    localparam int FSEL_W         = 3;
    localparam int WLEN_W         = 7;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_FSEL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WLEN = 1'd1;

    localparam logic [FSEL_W-1:0] FN_DELAY = 3'd0;
    localparam logic [FSEL_W-1:0] FN_DELTA = 3'd1;
    localparam logic [FSEL_W-1:0] FN_MEAN  = 3'd2;
    localparam logic [FSEL_W-1:0] FN_STD   = 3'd3;
    localparam logic [FSEL_W-1:0] FN_MIN   = 3'd4;
    localparam logic [FSEL_W-1:0] FN_MAX   = 3'd5;
endpackage
`default_nettype wire

[rtl/rws_ram.sv]
`default_nettype none
module rws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

[rtl/rolling_window_statistic.sv]
// Rolling window statistic over signed Q16.16 samples.
// Input channel: i_in_valid / o_in_stall with i_sample and i_series_start.
// Output channel: o_out_valid / i_out_stall with o_result_value and
// o_saturated. Configuration: i_cfg_we writes function select (index 0) or
// window length (index 1) from i_cfg_data; write only while idle.
// One word is processed at a time; the input stalls until its result is
// registered. Delay and delta read at most one stored sample; min, max and
// mean make one pass over the window memory, mean then runs a bit-serial
// divider; std deviation makes two passes over the window memory, one read
// per cycle, with the divider after each pass and a 32-step square root.
// The result sits in an output register, so the next word is taken while
// a result waits; a stalled receiver holds the finished result in place and
// the block waits to write back when a second result is ready.
// Reset clears the history, the config (delay, window of one) and the
// output valid. The window memory needs no clearing.
`default_nettype none
module rolling_window_statistic #(
    parameter int MAX_WINDOW = rws_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [rws_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [rws_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic signed [rws_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic                            i_series_start,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic signed [rws_pkg::SAMPLE_W-1:0]  o_result_value,
    output logic                                 o_saturated
);
    localparam int AW = $clog2(MAX_WINDOW);
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int SW = 32 + CW;
    localparam int DW = 64 + CW;
    localparam int IW = $clog2(DW + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DLY  = 4'd1;
    localparam logic [3:0] S_DLYW = 4'd2;
    localparam logic [3:0] S_P1   = 4'd3;
    localparam logic [3:0] S_DIV1 = 4'd4;
    localparam logic [3:0] S_P2   = 4'd5;
    localparam logic [3:0] S_DIV2 = 4'd6;
    localparam logic [3:0] S_SQRT = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0]                      r_state, n_state;
    logic [rws_pkg::FSEL_W-1:0]      r_fsel, n_fsel;
    logic [rws_pkg::WLEN_W-1:0]      r_wlen, n_wlen;
    logic signed [31:0]              r_x, n_x;
    logic signed [31:0]              r_fv, n_fv;
    logic [CW-1:0]                   r_k, n_k;
    logic [CW-1:0]                   r_cnt, n_cnt;
    logic [CW-1:0]                   r_ss, n_ss;
    logic [CW-1:0]                   r_j, n_j;
    logic [AW-1:0]                   r_wp, n_wp;
    logic [AW-1:0]                   r_addr, n_addr;
    logic                            r_pend, n_pend;
    logic                            r_first, n_first;
    logic signed [SW-1:0]            r_sum, n_sum;
    logic signed [31:0]              r_mm, n_mm;
    logic signed [31:0]              r_mean, n_mean;
    logic                            r_neg, n_neg;
    logic                            r_av, n_av;
    logic [31:0]                     r_abs, n_abs;
    logic                            r_sv, n_sv;
    logic [63:0]                     r_sq, n_sq;
    logic [DW-1:0]                   r_acc, n_acc;
    logic [DW-1:0]                   r_dq, n_dq;
    logic [CW-1:0]                   r_rem, n_rem;
    logic [IW-1:0]                   r_it, n_it;
    logic [63:0]                     r_rv, n_rv;
    logic [63:0]                     r_rres, n_rres;
    logic [63:0]                     r_rbit, n_rbit;
    logic signed [31:0]              r_tres, n_tres;
    logic                            r_tsat, n_tsat;
    logic                            r_out_valid, n_out_valid;
    logic signed [31:0]              r_res, n_res;
    logic                            r_sat, n_sat;

    logic                 mem_we, mem_re;
    logic [AW-1:0]        mem_raddr;
    logic [31:0]          mem_rdata;

    rws_ram #(
        .WIDTH(32),
        .DEPTH(MAX_WINDOW)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(r_wp),
        .i_wdata(r_x),
        .i_re   (mem_re),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    logic                 accept, out_free;
    logic [CW-1:0]        ss_eff, k_eff;
    logic [CW:0]          cnt_ext, slot_t;
    logic [AW-1:0]        wp_prev;
    logic                 issue_more, pass_busy;
    logic [CW:0]          rem_sh;
    logic                 rem_ge;
    logic signed [32:0]   dlt, dv;
    logic signed [31:0]   sv_in;
    logic [SW-1:0]        sum_abs;
    logic [31:0]          q_mag;
    logic [63:0]          sq_t;

    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_result_value = r_res;
    assign o_saturated = r_sat;

    always_comb begin
        ss_eff = i_series_start ? '0 : r_ss;
        if (r_wlen == '0) begin
            k_eff = CW'(1);
        end else if (32'(r_wlen) > MAX_WINDOW) begin
            k_eff = CW'(MAX_WINDOW);
        end else begin
            k_eff = CW'(r_wlen);
        end
        cnt_ext = (CW+1)'(ss_eff) + (CW+1)'(1);
        wp_prev = (r_wp == '0) ? AW'(MAX_WINDOW - 1) : r_wp - AW'(1);
        slot_t  = (CW+1)'(r_wp) + (CW+1)'(MAX_WINDOW) - (CW+1)'(r_k);
        if (slot_t >= (CW+1)'(MAX_WINDOW)) begin
            slot_t = slot_t - (CW+1)'(MAX_WINDOW);
        end
        issue_more = (r_j < r_cnt);
        rem_sh = {r_rem, r_dq[DW-1]};
        rem_ge = (rem_sh >= (CW+1)'(r_cnt));
        sum_abs = r_sum[SW-1] ? SW'(-r_sum) : SW'(r_sum);
        q_mag   = r_dq[31:0];
        sv_in   = r_first ? r_x : mem_rdata;
        dv      = 33'(sv_in) - 33'(r_mean);
        dlt     = 33'(r_x) - 33'(r_pend ? $signed(mem_rdata) : r_fv);
        sq_t    = r_rres + r_rbit;
        pass_busy = issue_more || r_pend || r_first || r_av || r_sv;
    end

    always_comb begin
        n_state = r_state;
        n_fsel = r_fsel;   n_wlen = r_wlen;
        n_x = r_x;         n_fv = r_fv;     n_k = r_k;     n_cnt = r_cnt;
        n_ss = r_ss;       n_j = r_j;       n_wp = r_wp;   n_addr = r_addr;
        n_pend = r_pend;   n_first = r_first;
        n_sum = r_sum;     n_mm = r_mm;     n_mean = r_mean; n_neg = r_neg;
        n_av = 1'b0;       n_abs = r_abs;   n_sv = 1'b0;   n_sq = r_sq;
        n_acc = r_acc;     n_dq = r_dq;     n_rem = r_rem; n_it = r_it;
        n_rv = r_rv;       n_rres = r_rres; n_rbit = r_rbit;
        n_tres = r_tres;   n_tsat = r_tsat;
        n_res = r_res;     n_sat = r_sat;
        n_out_valid = (r_out_valid && i_out_stall);
        mem_we = 1'b0;
        mem_re = 1'b0;
        mem_raddr = r_addr;

        if (i_cfg_we) begin
            case (i_cfg_index)
                rws_pkg::CFG_FSEL: n_fsel = i_cfg_data[rws_pkg::FSEL_W-1:0];
                rws_pkg::CFG_WLEN: n_wlen = i_cfg_data[rws_pkg::WLEN_W-1:0];
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_x    = i_sample;
                    n_ss   = ss_eff;
                    n_k    = k_eff;
                    n_cnt  = (cnt_ext < (CW+1)'(k_eff)) ? CW'(cnt_ext) : k_eff;
                    if (ss_eff == '0) begin
                        n_fv = i_sample;
                    end
                    n_j    = CW'(1);
                    n_addr = wp_prev;
                    n_pend = 1'b0;
                    n_sum  = SW'(i_sample);
                    n_mm   = i_sample;
                    n_tsat = 1'b0;
                    case (r_fsel)
                        rws_pkg::FN_DELAY, rws_pkg::FN_DELTA: n_state = S_DLY;
                        rws_pkg::FN_MEAN, rws_pkg::FN_STD,
                        rws_pkg::FN_MIN, rws_pkg::FN_MAX: n_state = S_P1;
                        default: begin
                            n_tres  = '0;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_DLY: begin
                mem_raddr = AW'(slot_t);
                mem_re    = (r_ss >= r_k);
                n_pend    = (r_ss >= r_k);
                n_state   = S_DLYW;
            end
            S_DLYW: begin
                if (r_fsel == rws_pkg::FN_DELAY) begin
                    n_tres = r_pend ? $signed(mem_rdata) : r_fv;
                end else if (dlt > 33'sd2147483647) begin
                    n_tres = 32'sh7FFFFFFF;
                    n_tsat = 1'b1;
                end else if (dlt < -33'sd2147483648) begin
                    n_tres = 32'sh80000000;
                    n_tsat = 1'b1;
                end else begin
                    n_tres = dlt[31:0];
                end
                n_pend  = 1'b0;
                n_state = S_DONE;
            end
            S_P1: begin
                if (issue_more) begin
                    mem_re = 1'b1;
                    n_addr = (r_addr == '0) ? AW'(MAX_WINDOW - 1) : r_addr - AW'(1);
                    n_j    = r_j + CW'(1);
                end
                n_pend = issue_more;
                if (r_pend) begin
                    n_sum = r_sum + SW'($signed(mem_rdata));
                    if (r_fsel == rws_pkg::FN_MIN ? ($signed(mem_rdata) < r_mm)
                                                  : ($signed(mem_rdata) > r_mm)) begin
                        n_mm = mem_rdata;
                    end
                end
                if (!issue_more && !r_pend) begin
                    if (r_fsel == rws_pkg::FN_MIN || r_fsel == rws_pkg::FN_MAX) begin
                        n_tres  = r_mm;
                        n_state = S_DONE;
                    end else begin
                        n_neg   = r_sum[SW-1];
                        n_dq    = {sum_abs, {(DW-SW){1'b0}}};
                        n_rem   = '0;
                        n_it    = IW'(SW);
                        n_state = S_DIV1;
                    end
                end
            end
            S_DIV1, S_DIV2: begin
                if (r_it != '0) begin
                    n_rem = rem_ge ? CW'(rem_sh - (CW+1)'(r_cnt)) : CW'(rem_sh);
                    n_dq  = {r_dq[DW-2:0], rem_ge};
                    n_it  = r_it - IW'(1);
                end else if (r_state == S_DIV1) begin
                    n_mean = r_neg ? -$signed(q_mag) : $signed(q_mag);
                    if (r_fsel == rws_pkg::FN_MEAN) begin
                        n_tres  = r_neg ? -$signed(q_mag) : $signed(q_mag);
                        n_state = S_DONE;
                    end else begin
                        n_first = 1'b1;
                        n_j     = CW'(1);
                        n_addr  = wp_prev;
                        n_pend  = 1'b0;
                        n_acc   = '0;
                        n_state = S_P2;
                    end
                end else begin
                    n_rv    = r_dq[63:0];
                    n_rres  = '0;
                    n_rbit  = 64'h4000_0000_0000_0000;
                    n_it    = IW'(32);
                    n_state = S_SQRT;
                end
            end
            S_P2: begin
                if (issue_more) begin
                    mem_re = 1'b1;
                    n_addr = (r_addr == '0) ? AW'(MAX_WINDOW - 1) : r_addr - AW'(1);
                    n_j    = r_j + CW'(1);
                end
                n_pend  = issue_more;
                n_first = 1'b0;
                // deviation, square, accumulate: one stage each
                if (r_first || r_pend) begin
                    n_av  = 1'b1;
                    n_abs = dv[32] ? 32'(-dv) : 32'(dv);
                end
                if (r_av) begin
                    n_sv = 1'b1;
                    n_sq = 64'(r_abs) * 64'(r_abs);
                end
                if (r_sv) begin
                    n_acc = r_acc + DW'(r_sq);
                end
                if (!pass_busy) begin
                    n_dq    = r_acc;
                    n_rem   = '0;
                    n_it    = IW'(DW);
                    n_state = S_DIV2;
                end
            end
            S_SQRT: begin
                if (r_it != '0) begin
                    if (r_rv >= sq_t) begin
                        n_rv   = r_rv - sq_t;
                        n_rres = (r_rres >> 1) + r_rbit;
                    end else begin
                        n_rres = r_rres >> 1;
                    end
                    n_rbit = r_rbit >> 2;
                    n_it   = r_it - IW'(1);
                end else begin
                    n_tres  = r_rres[31:0];
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    mem_we      = 1'b1;
                    n_wp        = (r_wp == AW'(MAX_WINDOW - 1)) ? '0 : r_wp + AW'(1);
                    if (r_ss < CW'(MAX_WINDOW)) begin
                        n_ss = r_ss + CW'(1);
                    end
                    n_res       = r_tres;
                    n_sat       = r_tsat;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fsel      <= rws_pkg::FN_DELAY;
            r_wlen      <= rws_pkg::WLEN_W'(1);
            r_wp        <= '0;
            r_ss        <= '0;
            r_fv        <= '0;
            r_pend      <= 1'b0;
            r_first     <= 1'b0;
            r_av        <= 1'b0;
            r_sv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fsel      <= n_fsel;
            r_wlen      <= n_wlen;
            r_wp        <= n_wp;
            r_ss        <= n_ss;
            r_fv        <= n_fv;
            r_pend      <= n_pend;
            r_first     <= n_first;
            r_av        <= n_av;
            r_sv        <= n_sv;
            r_out_valid <= n_out_valid;
        end
        r_x    <= n_x;     r_k    <= n_k;    r_cnt  <= n_cnt;
        r_j    <= n_j;     r_addr <= n_addr; r_sum  <= n_sum;
        r_mm   <= n_mm;    r_mean <= n_mean; r_neg  <= n_neg;
        r_abs  <= n_abs;   r_sq   <= n_sq;   r_acc  <= n_acc;
        r_dq   <= n_dq;    r_rem  <= n_rem;  r_it   <= n_it;
        r_rv   <= n_rv;    r_rres <= n_rres; r_rbit <= n_rbit;
        r_tres <= n_tres;  r_tsat <= n_tsat;
        r_res  <= n_res;   r_sat  <= n_sat;
    end
endmodule
`default_nettype wire
